// File: src/tfd_pkg.sv
package tfd_pkg;

  // Input kind codes as they arrive on the stream
  localparam logic [2:0] KIND_DOWN    = 3'd0;
  localparam logic [2:0] KIND_MOTION  = 3'd1;
  localparam logic [2:0] KIND_UP      = 3'd2;
  localparam logic [2:0] KIND_FRAME   = 3'd3;
  localparam logic [2:0] KIND_TCANCEL = 3'd4;
  localparam logic [2:0] KIND_RESET   = 3'd5;
  localparam logic [2:0] KIND_CANCEL  = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_IGNORE = 2'd0;
  localparam logic [1:0] ST_BEGUN  = 2'd1;
  localparam logic [1:0] ST_CANCEL = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MOVE   = 2'd0;
  localparam logic [1:0] REG_SPREAD = 2'd1;
  localparam logic [1:0] REG_TIME   = 2'd2;

  localparam logic [16:0] MOVE_RST   = 17'd160;
  localparam logic [16:0] SPREAD_RST = 17'd800;
  localparam logic [15:0] TIME_RST   = 16'd300;

  typedef logic signed [4:0] count_t;
  localparam count_t FC_MAX = 5'sd15;
  localparam count_t FC_MIN = 5'sb10000;
  localparam count_t FC_ONE = 5'sd1;
  localparam count_t FC_TWO = 5'sd2;
  localparam count_t FC_ZERO = 5'sd0;

  typedef enum logic [2:0] {
    OP_DOWN,
    OP_MOTION,
    OP_UP,
    OP_TCANCEL,
    OP_RESET,
    OP_CANCEL,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        slot;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [31:0] time_ms;
  } evt_t;

  typedef struct packed {
    logic [16:0] move_limit;
    logic [16:0] spread_limit;
    logic [15:0] time_limit;
  } cfg_t;

endpackage

// File: src/two_finger_tap_detector_top.sv
// Two-finger tap recognizer. Touch events (down, motion, up, frame, touch
// cancel, reset and cancel commands) enter on the in_ stream, one beat per
// clock when the block is not stalled, and each event yields exactly one
// result beat on the out_ stream carrying a status (ignore, begun,
// cancelled, finished) and the cancel flag after the event. An event is
// decoded on entry and parked in a QUEUE_DEPTH-entry queue; the gesture
// state is updated as the event leaves the queue, and the result sits in
// an output register, so an event taken passes through the queue entry and
// then the output register; the sustained rate is one event per cycle while
// the output is not held off. The queue keeps taking events while the
// output is held off, until it fills. The move, spread and time limits are
// APB registers at byte addresses 0, 4 and 8 and should only be written
// while no event is in flight.
module two_finger_tap_detector_top import tfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,    // [2:0] kind, [3] slot
  input  logic [63:0] in_tdata,    // [15:0] x_pos, [31:16] y_pos, [63:32] time_ms
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [1:0] status, [2] cancelled_flag, [7:3] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t        cfg_r, cfg_nxt;
  logic        cfg_wr;
  logic        q_full, q_valid, push, pop;
  evt_t        evt_in, evt_out;
  logic [1:0]  status;
  logic        cflag;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MOVE:   cfg_nxt.move_limit   = cfg_pwdata[16:0];
        REG_SPREAD: cfg_nxt.spread_limit = cfg_pwdata[16:0];
        REG_TIME:   cfg_nxt.time_limit   = cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_limit   <= MOVE_RST;
      cfg_r.spread_limit <= SPREAD_RST;
      cfg_r.time_limit   <= TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MOVE:   cfg_prdata = {15'b0, cfg_r.move_limit};
      REG_SPREAD: cfg_prdata = {15'b0, cfg_r.spread_limit};
      REG_TIME:   cfg_prdata = {16'b0, cfg_r.time_limit};
      default:    cfg_prdata = '0;
    endcase
  end

  tfd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .evt       (evt_in)
  );

  tfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .din     (evt_in),
    .pop     (pop),
    .dout    (evt_out),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  tfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .evt        (evt_out),
    .cfg        (cfg_r),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_cflag  (cflag)
  );

  assign out_tdata = {5'b0, cflag, status};

  // a reset command always leaves the cancel flag clear
  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && evt_out.op == OP_RESET |=> out_tvalid && !out_tdata[2] &&
    out_tdata[1:0] == ST_IGNORE)
    else $error("reset command did not clear cancel flag");

  // a touch cancel reports cancelled with the flag set
  a_tcancel: assert property (@(posedge clk) disable iff (!rst_n)
    pop && evt_out.op == OP_TCANCEL |=> out_tvalid && out_tdata[2] &&
    out_tdata[1:0] == ST_CANCEL)
    else $error("touch cancel result wrong");

  // a full queue stays full until the back end drains an entry
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !pop |=> !in_tready)
    else $error("queue space appeared without a pop");

endmodule

// File: src/tfd_front.sv
module tfd_front import tfd_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,   // [2:0] kind, [3] slot
  input  logic [63:0] in_tdata,   // [15:0] x_pos, [31:16] y_pos, [63:32] time_ms
  input  logic        q_full,
  output logic        push,
  output evt_t        evt
);

  op_t op;

  always_comb begin
    unique case (in_tuser[2:0])
      KIND_DOWN:    op = OP_DOWN;
      KIND_MOTION:  op = OP_MOTION;
      KIND_UP:      op = OP_UP;
      KIND_TCANCEL: op = OP_TCANCEL;
      KIND_RESET:   op = OP_RESET;
      KIND_CANCEL:  op = OP_CANCEL;
      default:      op = OP_NOP;    // frame and the unused code
    endcase
  end

  assign in_tready   = !q_full;
  assign push        = in_tvalid && !q_full;
  assign evt.op      = op;
  assign evt.slot    = in_tuser[3];
  assign evt.x_pos   = in_tdata[15:0];
  assign evt.y_pos   = in_tdata[31:16];
  assign evt.time_ms = in_tdata[63:32];

endmodule

// File: src/tfd_queue.sv
module tfd_queue import tfd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t din,
  input  logic pop,
  output evt_t dout,
  output logic q_valid,
  output logic q_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  evt_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CW'(DEPTH));
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: src/tfd_back.sv
module tfd_back import tfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  evt_t       evt,
  input  cfg_t       cfg,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_cflag
);

  count_t      fc_r, fc_nxt;
  logic        canc_r, canc_nxt;
  logic [15:0] sx_r [2];
  logic [15:0] sy_r [2];
  logic [15:0] cx_r [2];
  logic [15:0] cy_r [2];
  logic [15:0] sx_nxt [2];
  logic [15:0] sy_nxt [2];
  logic [15:0] cx_nxt [2];
  logic [15:0] cy_nxt [2];
  logic [31:0] st_r, st_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  os_r, os_nxt;
  logic        oc_r;

  count_t      fc_inc, fc_dec;
  logic [15:0] sx_dn [2];
  logic [15:0] sy_dn [2];
  logic [15:0] cx_mv [2];
  logic [15:0] cy_mv [2];
  logic [16:0] d0, d1, spread;
  logic [31:0] dt;
  logic        up_pass;
  logic [1:0]  status;

  function automatic logic [16:0] absdiff(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  assign pop = q_valid && (!ov_r || out_ready);

  assign fc_inc = (fc_r < FC_MAX) ? fc_r + FC_ONE : fc_r;
  assign fc_dec = (fc_r > FC_MIN) ? fc_r - FC_ONE : fc_r;

  // start points as a down would leave them, current points as a motion would
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sx_dn[i] = (fc_inc <= FC_TWO && evt.slot == 1'(i)) ? evt.x_pos : sx_r[i];
      sy_dn[i] = (fc_inc <= FC_TWO && evt.slot == 1'(i)) ? evt.y_pos : sy_r[i];
      cx_mv[i] = (evt.slot == 1'(i)) ? evt.x_pos : cx_r[i];
      cy_mv[i] = (evt.slot == 1'(i)) ? evt.y_pos : cy_r[i];
    end
  end

  assign d0      = absdiff(cx_mv[0], sx_r[0]) + absdiff(cy_mv[0], sy_r[0]);
  assign d1      = absdiff(cx_mv[1], sx_r[1]) + absdiff(cy_mv[1], sy_r[1]);
  assign dt      = evt.time_ms - st_r;
  assign spread  = absdiff(sx_r[0], sx_r[1]) + absdiff(sy_r[0], sy_r[1]);
  assign up_pass = !canc_r && (dt < {16'b0, cfg.time_limit}) && (spread < cfg.spread_limit);

  always_comb begin
    fc_nxt   = fc_r;
    canc_nxt = canc_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    st_nxt   = st_r;
    status   = ST_IGNORE;
    if (pop) begin
      unique case (evt.op)
        OP_DOWN: begin
          fc_nxt = fc_inc;
          if (!canc_r) begin
            sx_nxt = sx_dn;
            sy_nxt = sy_dn;
            if (fc_inc == FC_TWO) begin
              st_nxt = evt.time_ms;
              cx_nxt = sx_dn;
              cy_nxt = sy_dn;
              status = ST_BEGUN;
            end else if (fc_inc > FC_TWO) begin
              canc_nxt = 1'b1;
              status   = ST_CANCEL;
            end
          end
        end
        OP_MOTION: begin
          if (!canc_r) begin
            cx_nxt = cx_mv;
            cy_nxt = cy_mv;
            if (d0 > cfg.move_limit || d1 > cfg.move_limit) begin
              canc_nxt = 1'b1;
              status   = ST_CANCEL;
            end
          end
        end
        OP_UP: begin
          fc_nxt = fc_dec;
          if (fc_dec <= FC_ZERO) begin
            if (up_pass) begin
              status = ST_FINISH;
            end else begin
              fc_nxt    = FC_ZERO;
              st_nxt    = '0;
              canc_nxt  = 1'b0;
              sx_nxt[0] = '0;
              sy_nxt[0] = '0;
            end
          end
        end
        OP_TCANCEL: begin
          canc_nxt = 1'b1;
          status   = ST_CANCEL;
        end
        OP_RESET: begin
          fc_nxt    = FC_ZERO;
          st_nxt    = '0;
          canc_nxt  = 1'b0;
          sx_nxt[0] = '0;
          sy_nxt[0] = '0;
        end
        OP_CANCEL: begin
          canc_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    os_nxt = os_r;
    if (pop) begin
      ov_nxt = 1'b1;
      os_nxt = status;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r   <= FC_ZERO;
      canc_r <= 1'b0;
      st_r   <= '0;
      sx_r   <= '{default: '0};
      sy_r   <= '{default: '0};
      cx_r   <= '{default: '0};
      cy_r   <= '{default: '0};
      ov_r   <= 1'b0;
    end else begin
      fc_r   <= fc_nxt;
      canc_r <= canc_nxt;
      st_r   <= st_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      oc_r <= canc_nxt;
    end
    os_r <= os_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_cflag  = oc_r;

endmodule

// File: test/tap_result_checker.sv
`timescale 1ns / 1ps

// Watches the event stream, the result stream and the register port of the
// tap detector, predicts one verdict per event and compares in order.
module tap_result_checker import tfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [3:0]  in_tuser,    // [2:0] kind, [3] slot
  input  logic [63:0] in_tdata,    // [15:0] x_pos, [31:16] y_pos, [63:32] time_ms
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,   // [1:0] status, [2] cancelled_flag, [7:3] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0] status;
    logic       flag;
  } verdict_t;

  verdict_t    verdict_q[$];
  verdict_t    want;
  int          mism = 0;

  // shadow of the limits and the gesture state
  logic [16:0] mv_lim;
  logic [16:0] sp_lim;
  logic [15:0] tm_lim;
  count_t      fingers;
  logic        gesture_off;
  logic [15:0] sx [2];
  logic [15:0] sy [2];
  logic [15:0] cx [2];
  logic [15:0] cy [2];
  logic [31:0] t0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [16:0] span(input logic [15:0] ax, bx, ay, by);
    logic [16:0] dx, dy;
    dx = (ax >= bx) ? {1'b0, ax - bx} : {1'b0, bx - ax};
    dy = (ay >= by) ? {1'b0, ay - by} : {1'b0, by - ay};
    return dx + dy;
  endfunction

  // slot 1 start point and the current points survive this
  function automatic void clear_gesture();
    fingers     = FC_ZERO;
    t0          = '0;
    gesture_off = 1'b0;
    sx[0]       = '0;
    sy[0]       = '0;
  endfunction

  function automatic verdict_t next_tap_verdict(input logic [2:0] kind, input logic slot,
                                                input logic [15:0] x, y, input logic [31:0] t);
    verdict_t    v;
    logic [16:0] d0, d1, spread;
    logic [31:0] dt;
    v.status = ST_IGNORE;
    case (kind)
      KIND_DOWN: begin
        if (fingers < FC_MAX) fingers = fingers + FC_ONE;
        if (!gesture_off) begin
          // negative counts still record the start point
          if (fingers <= FC_TWO) begin
            sx[slot] = x;
            sy[slot] = y;
          end
          if (fingers == FC_TWO) begin
            t0    = t;
            cx[0] = sx[0];
            cy[0] = sy[0];
            cx[1] = sx[1];
            cy[1] = sy[1];
            v.status = ST_BEGUN;
          end else if (fingers > FC_TWO) begin
            gesture_off = 1'b1;
            v.status    = ST_CANCEL;
          end
        end
      end
      KIND_MOTION: begin
        if (!gesture_off) begin
          cx[slot] = x;
          cy[slot] = y;
          d0 = span(cx[0], sx[0], cy[0], sy[0]);
          d1 = span(cx[1], sx[1], cy[1], sy[1]);
          if (d0 > mv_lim || d1 > mv_lim) begin
            gesture_off = 1'b1;
            v.status    = ST_CANCEL;
          end
        end
      end
      KIND_UP: begin
        if (fingers > FC_MIN) fingers = fingers - FC_ONE;
        if (fingers <= FC_ZERO) begin
          dt     = t - t0;
          spread = span(sx[0], sx[1], sy[0], sy[1]);
          if (!gesture_off && dt < {16'd0, tm_lim} && spread < sp_lim) v.status = ST_FINISH;
          else clear_gesture();
        end
      end
      KIND_TCANCEL: begin
        gesture_off = 1'b1;
        v.status    = ST_CANCEL;
      end
      KIND_RESET:  clear_gesture();
      KIND_CANCEL: gesture_off = 1'b1;
      default: ;
    endcase
    v.flag = gesture_off;
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mv_lim  = MOVE_RST;
      sp_lim  = SPREAD_RST;
      tm_lim  = TIME_RST;
      clear_gesture();
      sx[1]   = '0;
      sy[1]   = '0;
      cx[0]   = '0;
      cx[1]   = '0;
      cy[0]   = '0;
      cy[1]   = '0;
      verdict_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_MOVE:   mv_lim = cfg_pwdata[16:0];
          REG_SPREAD: sp_lim = cfg_pwdata[16:0];
          REG_TIME:   tm_lim = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        verdict_q.push_back(next_tap_verdict(in_tuser[2:0], in_tuser[3], in_tdata[15:0],
                                             in_tdata[31:16], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("unexpected result beat: status %0d flag %0b", out_tdata[1:0], out_tdata[2]);
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[1:0] != want.status || out_tdata[2] != want.flag) begin
            mism++;
            if (mism <= 10)
              $display("result mismatch: status %0d flag %0b, expected status %0d flag %0b",
                       out_tdata[1:0], out_tdata[2], want.status, want.flag);
          end
        end
      end
    end
    outstanding <= verdict_q.size();
    fail_count  <= mism;
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb import tfd_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [3:0]  in_tuser = '0;   // [2:0] kind, [3] slot
  logic [63:0] in_tdata = '0;   // [15:0] x_pos, [31:16] y_pos, [63:32] time_ms
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [1:0] status, [2] cancelled_flag, [7:3] zero
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          fail_count;
  int          outstanding;
  int          sent = 0;
  logic [31:0] now_ms = 32'd1000;
  logic        quiet_in = 1'b0;
  logic        quiet_out = 1'b0;
  logic        choke_req = 1'b0;

  two_finger_tap_detector_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tap_result_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (choke_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        choke_req = 1'b0;
      end
      out_tready <= quiet_out || ($urandom_range(99) >= 21);
    end
  end

  // one event beat; valid stays high between back-to-back beats
  task automatic beat(input logic [2:0] kind, input logic slot, input logic [15:0] x, y,
                      input logic [31:0] t);
    while (!quiet_in && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {slot, kind};
    in_tdata  <= {t, y, x};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [16:0] mv, sp, input logic [15:0] tm);
    reg_write(REG_MOVE, {15'd0, mv});
    reg_write(REG_SPREAD, {15'd0, sp});
    reg_write(REG_TIME, {16'd0, tm});
  endtask

  // drain: stop offering and wait for every verdict to come back
  task automatic settle();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // well-formed two-finger tap with random content and an occasional twist
  task automatic tap_gesture();
    logic [15:0] x0, y0, x1, y1;
    logic [31:0] t, t_end;
    logic        a, s;
    int          flavor, nmot, jit, i;
    flavor = $urandom_range(0, 9);
    if ($urandom_range(0, 19) == 0) now_ms = $urandom();
    t  = now_ms;
    a  = 1'($urandom_range(0, 1));
    x0 = 16'($urandom());
    y0 = 16'($urandom());
    if (flavor == 0) begin
      x1 = 16'($urandom());
      y1 = 16'($urandom());
    end else begin
      x1 = x0 + 16'($urandom_range(0, 500)) - 16'd250;
      y1 = y0 + 16'($urandom_range(0, 500)) - 16'd250;
    end
    beat(KIND_DOWN, a, x0, y0, t);
    if (flavor == 1) beat(KIND_FRAME, 1'($urandom_range(0, 1)), 16'($urandom()),
                          16'($urandom()), $urandom());
    t = t + $urandom_range(0, 30);
    beat(KIND_DOWN, ~a, x1, y1, t);
    jit  = (flavor == 2) ? 400 : 60;
    nmot = $urandom_range(0, 4);
    for (i = 0; i < nmot; i++) begin
      s = 1'($urandom_range(0, 1));
      beat(KIND_MOTION, s, (s ? x1 : x0) + 16'($urandom_range(0, 2 * jit)) - 16'(jit),
           (s ? y1 : y0) + 16'($urandom_range(0, 2 * jit)) - 16'(jit), t + 32'(i));
    end
    case (flavor)
      3: beat(KIND_DOWN, 1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()), t);
      4: beat(KIND_TCANCEL, 1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()), t);
      5: beat(KIND_CANCEL, 1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()), t);
      6: beat(KIND_RESET, 1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()), t);
      default: ;
    endcase
    t_end = now_ms + $urandom_range(0, (flavor == 7) ? 2000 : 280);
    beat(KIND_UP, a, x0, y0, t_end - $urandom_range(0, 20));
    beat(KIND_UP, ~a, x1, y1, t_end);
    if (flavor == 3) beat(KIND_UP, 1'($urandom_range(0, 1)), 16'($urandom()),
                          16'($urandom()), t_end);
    now_ms = t_end + $urandom_range(20, 500);
  endtask

  task automatic random_phase(input int n);
    int start, r, k;
    logic [2:0] kd;
    start = sent;
    while (sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        tap_gesture();
      end else if (r < 85) begin
        k = $urandom_range(1, 6);
        repeat (k) beat(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                        16'($urandom()), 16'($urandom()), $urandom());
        if ($urandom_range(0, 1)) beat(KIND_RESET, 1'b0, 16'd0, 16'd0, now_ms);
      end else if (r < 90) begin
        // drive the finger count into saturation either way
        kd = $urandom_range(0, 1) ? KIND_DOWN : KIND_UP;
        k  = $urandom_range(16, 18);
        repeat (k) beat(kd, 1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()),
                        $urandom());
        beat(KIND_RESET, 1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()), now_ms);
      end else begin
        beat(KIND_DOWN, 1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()), now_ms);
        beat(KIND_UP, 1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()),
             now_ms + $urandom_range(0, 400));
        now_ms = now_ms + $urandom_range(400, 900);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset limits
    beat(KIND_DOWN,    1'b0, 16'd100,    16'd100,    32'd1000);
    beat(KIND_DOWN,    1'b1, 16'd150,    16'd180,    32'd1010);
    beat(KIND_MOTION,  1'b0, 16'd200,    16'd100,    32'd1020);
    beat(KIND_FRAME,   1'b0, 16'd0,      16'd0,      32'd1030);
    beat(KIND_UP,      1'b0, 16'd200,    16'd100,    32'd1100);
    beat(KIND_UP,      1'b1, 16'd150,    16'd180,    32'd1200);   // clean tap
    beat(3'd7,         1'b1, 16'hFFFF,   16'hFFFF,   32'hFFFF_FFFF);
    beat(KIND_DOWN,    1'b1, 16'hFFFF,   16'hFFFF,   32'hFFFF_FFF0);
    beat(KIND_DOWN,    1'b0, 16'hFFF0,   16'hFFFF,   32'hFFFF_FFF8);
    beat(KIND_MOTION,  1'b1, 16'h0000,   16'h0000,   32'hFFFF_FFFA);  // drifts too far
    beat(KIND_MOTION,  1'b0, 16'h1234,   16'h5678,   32'hFFFF_FFFC);
    beat(KIND_UP,      1'b0, 16'd0,      16'd0,      32'd2);
    beat(KIND_UP,      1'b1, 16'd0,      16'd0,      32'd4);
    beat(KIND_DOWN,    1'b0, 16'd0,      16'd0,      32'd5);
    beat(KIND_DOWN,    1'b1, 16'd0,      16'd0,      32'd10);
    beat(KIND_DOWN,    1'b0, 16'd7,      16'd7,      32'd12);   // third finger
    beat(KIND_RESET,   1'b0, 16'd0,      16'd0,      32'd15);
    beat(KIND_DOWN,    1'b0, 16'd0,      16'd0,      32'd20);
    beat(KIND_DOWN,    1'b1, 16'd1000,   16'd0,      32'd30);   // fingers too far apart
    beat(KIND_UP,      1'b1, 16'd1000,   16'd0,      32'd40);
    beat(KIND_UP,      1'b0, 16'd0,      16'd0,      32'd50);
    beat(KIND_TCANCEL, 1'b0, 16'd0,      16'd0,      32'd60);
    beat(KIND_CANCEL,  1'b1, 16'd0,      16'd0,      32'd70);
    beat(KIND_RESET,   1'b0, 16'd0,      16'd0,      32'd80);
    beat(KIND_UP,      1'b0, 16'd0,      16'd0,      32'd100);  // up with no finger down
    settle();

    random_phase(320);
    settle();

    // lowest limits, with a long result-side hold-off while events keep coming
    set_limits(17'd0, 17'd0, 16'd0);
    choke_req = 1'b1;
    random_phase(320);
    settle();

    set_limits(17'd131070, 17'd131070, 16'd65535);
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    random_phase(320);
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    settle();

    set_limits(17'($urandom_range(50, 400)), 17'($urandom_range(200, 2000)),
               16'($urandom_range(100, 1000)));
    random_phase(320);
    settle();

    set_limits(MOVE_RST, SPREAD_RST, TIME_RST);
    random_phase(320);
    settle();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
src/tfd_pkg.sv
src/tfd_front.sv
src/tfd_queue.sv
src/tfd_back.sv
src/two_finger_tap_detector_top.sv
test/tap_result_checker.sv
test/tb.sv
